// File: src/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and codes for the sprite row decoder: decode phases, stream
// actions, opcode groups and the per-frame state and result records.
// ----------------------------------------------------------------------------
package rsd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_OPCODE    = 3'd1,
    PH_ONE_PIXEL = 3'd2,
    PH_RUN_ALPHA = 3'd3,
    PH_RUN_INDEX = 3'd4,
    PH_LITERAL   = 3'd5,
    PH_REPEAT    = 3'd6,
    PH_SKIP      = 3'd7
  } phase_t;

  // stream action carried in tuser
  localparam logic [1:0] ACT_CONTINUE  = 2'd0;
  localparam logic [1:0] ACT_ROW_START = 2'd1;
  localparam logic [1:0] ACT_FRAME_END = 2'd2;

  // opcode group in the top two bits of an opcode byte
  localparam logic [1:0] OPC_SHORT   = 2'b00;
  localparam logic [1:0] OPC_LITERAL = 2'b01;
  localparam logic [1:0] OPC_REPEAT  = 2'b10;
  localparam logic [1:0] OPC_SKIP    = 2'b11;

  localparam logic [7:0]  ALPHA_OPAQUE  = 8'h20;
  localparam logic [5:0]  SKIP_BYTES    = 6'd2;
  localparam logic [10:0] WIDTH_RESET   = 11'd64;
  localparam logic        KIND_RUN      = 1'b0;
  localparam logic        KIND_FRAME    = 1'b1;
  localparam int          OUT_BITS      = 48;

  typedef struct packed {
    phase_t      phase;
    logic [10:0] x;
    logic [9:0]  row;
    logic        started;
    logic [5:0]  pcount;
    logic [7:0]  palpha;
    logic        odd_empty;
  } rsd_state_t;

  typedef struct packed {
    logic        repeat_even_rows;
    logic [7:0]  alpha;
    logic [7:0]  palette_index;
    logic [5:0]  run_length;
    logic [9:0]  x_start;
    logic [9:0]  row;
    logic        kind;
  } rsd_result_t;

  localparam rsd_state_t STATE_RESET = '{
    phase: PH_IDLE, x: 11'd0, row: 10'd0, started: 1'b0,
    pcount: 6'd0, palpha: 8'd0, odd_empty: 1'b1
  };

endpackage

// File: src/rle_sprite_row_decoder.sv
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder
// Decodes a run-length-coded sprite frame, one byte per transaction, into
// pixel runs and one frame done report per frame.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tuser: action; tdata: data_byte
//  m_*      | out       | tuser: kind; tdata: run fields / frame report
//  frame_*  | in        | frame_width write (we + wdata), no read-back
//
//  One byte is accepted per cycle; the decode step sits between the decode
//  state registers and the output register, so a result shows in the cycle
//  after its byte. s_tready is low only while a result waits on m_tready.
//  Synchronous reset returns the frame state and sets the width to 64.
// ----------------------------------------------------------------------------
module rle_sprite_row_decoder
  import rsd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [9:0] row, [19:10] x_start, [25:20] run_length,
                                 // [33:26] palette_index, [41:34] alpha,
                                 // [42] repeat_even_rows, [47:43] zero
  output logic [0:0]  m_tuser,   // [0] kind
  input  logic        frame_width_we,
  input  logic [10:0] frame_width_wdata
);

  localparam int WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int ROW_CAP   = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

  logic [10:0] frame_width;
  logic [10:0] width_act;
  rsd_state_t  state;
  rsd_state_t  state_next;
  logic        emit;
  rsd_result_t res;
  rsd_result_t out_res;
  logic        accept;

  assign width_act = (frame_width > 11'(WIDTH_CAP)) ? 11'(WIDTH_CAP) : frame_width;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  rsd_step #(
    .WIDTH_CAP (WIDTH_CAP),
    .ROW_CAP   (ROW_CAP)
  ) u_step (
    .cur       (state),
    .width     (width_act),
    .action    (s_tuser),
    .data_byte (s_tdata),
    .nxt       (state_next),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RESET;
    end else if (frame_width_we) begin
      frame_width <= frame_width_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload loads only when a result is produced; hold otherwise
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {5'd0, out_res.repeat_even_rows, out_res.alpha, out_res.palette_index,
                    out_res.run_length, out_res.x_start, out_res.row};

endmodule

// File: src/rsd_step.sv
// ----------------------------------------------------------------------------
// rsd_step
// Next-state and run logic for one stream byte: opcode decode, clipping to
// the row width and column advance.
// ----------------------------------------------------------------------------
module rsd_step
  import rsd_pkg::*;
#(
  parameter int WIDTH_CAP = 1024,
  parameter int ROW_CAP   = 1024
) (
  input  rsd_state_t  cur,
  input  logic [10:0] width,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output rsd_state_t  nxt,
  output logic        emit,
  output rsd_result_t res
);

  localparam logic [10:0] WCAP     = 11'(WIDTH_CAP);
  localparam logic [10:0] ROW_LAST = 11'(ROW_CAP - 1);

  typedef struct packed {
    logic        ok;
    rsd_result_t r;
  } run_t;

  function automatic rsd_state_t finish_op(rsd_state_t s, logic [5:0] len,
                                           logic [10:0] w);
    logic [11:0] nx;
    nx = {1'b0, s.x} + {6'd0, len};
    s.x = (nx > {1'b0, WCAP}) ? WCAP : nx[10:0];
    s.phase = (s.x >= w) ? PH_IDLE : PH_OPCODE;
    return s;
  endfunction

  function automatic run_t emit_run(rsd_state_t s, logic [10:0] w, logic [5:0] len,
                                    logic [7:0] idx, logic [7:0] alpha);
    run_t        o;
    logic [10:0] room;
    logic [5:0]  len_c;
    o = '0;
    room = w - s.x;
    len_c = ({5'd0, len} > room) ? room[5:0] : len;
    if (s.x < w && alpha != 8'd0 && len_c != 6'd0) begin
      o.ok = 1'b1;
      o.r.kind = KIND_RUN;
      o.r.row = s.row;
      o.r.x_start = s.x[9:0];
      o.r.run_length = len_c;
      o.r.palette_index = idx;
      o.r.alpha = alpha;
    end
    return o;
  endfunction

  rsd_state_t st;
  run_t       run;
  logic       take;

  always_comb begin
    st = cur;
    run = '0;
    take = 1'b0;
    res = '0;
    emit = 1'b0;

    case (action)
      ACT_FRAME_END: begin
        st = STATE_RESET;
      end
      ACT_ROW_START: begin
        if (cur.started && {1'b0, cur.row} >= ROW_LAST) begin
          st.phase = PH_IDLE;
        end else begin
          st.row = cur.started ? cur.row + 10'd1 : 10'd0;
          st.started = 1'b1;
          st.x = 11'd0;
          st.pcount = 6'd0;
          st.palpha = 8'd0;
          if (width == 11'd0) begin
            st.phase = PH_IDLE;
          end else begin
            st.phase = PH_OPCODE;
            take = 1'b1;
          end
        end
      end
      ACT_CONTINUE: begin
        take = (cur.phase != PH_IDLE);
      end
      default: begin
      end
    endcase

    if (take) begin
      case (st.phase)
        PH_OPCODE: begin
          if (data_byte == 8'd0) begin
            st.phase = PH_IDLE;
          end else begin
            case (data_byte[7:6])
              OPC_SHORT: begin
                if (st.row[0]) st.odd_empty = 1'b0;
                if (data_byte[5]) begin
                  st.palpha = {3'd0, data_byte[4:0]};
                  st.phase = PH_ONE_PIXEL;
                end else begin
                  st.pcount = {1'b0, data_byte[4:0]};
                  st.phase = PH_RUN_ALPHA;
                end
              end
              OPC_LITERAL: begin
                if (st.row[0]) st.odd_empty = 1'b0;
                st.pcount = data_byte[5:0];
                if (data_byte[5:0] == 6'd0) st = finish_op(st, 6'd0, width);
                else st.phase = PH_LITERAL;
              end
              OPC_REPEAT: begin
                if (st.row[0]) st.odd_empty = 1'b0;
                st.pcount = data_byte[5:0];
                st.phase = PH_REPEAT;
              end
              default: begin
                if (data_byte[5:0] == 6'd0) begin
                  st.pcount = SKIP_BYTES;
                  st.phase = PH_SKIP;
                end else begin
                  st = finish_op(st, data_byte[5:0], width);
                end
              end
            endcase
          end
        end
        PH_ONE_PIXEL: begin
          run = emit_run(st, width, 6'd1, data_byte, st.palpha);
          st = finish_op(st, 6'd1, width);
        end
        PH_RUN_ALPHA: begin
          st.palpha = data_byte;
          st.phase = PH_RUN_INDEX;
        end
        PH_RUN_INDEX: begin
          if (st.palpha != 8'd0) begin
            run = emit_run(st, width, st.pcount, data_byte, st.palpha);
            st = finish_op(st, st.pcount, width);
          end else begin
            st = finish_op(st, 6'd0, width);
          end
        end
        PH_LITERAL: begin
          run = emit_run(st, width, 6'd1, data_byte, ALPHA_OPAQUE);
          st.pcount = st.pcount - 6'd1;
          if (st.pcount == 6'd0) begin
            st = finish_op(st, 6'd1, width);
          end else begin
            // advance one column, stay in the literal
            st.x = (st.x >= WCAP) ? WCAP : st.x + 11'd1;
          end
        end
        PH_REPEAT: begin
          run = emit_run(st, width, st.pcount, data_byte, ALPHA_OPAQUE);
          st = finish_op(st, st.pcount, width);
        end
        PH_SKIP: begin
          st.pcount = st.pcount - 6'd1;
          if (st.pcount == 6'd0) st = finish_op(st, 6'd0, width);
        end
        default: begin
        end
      endcase
    end

    if (action == ACT_FRAME_END) begin
      emit = 1'b1;
      res.kind = KIND_FRAME;
      res.repeat_even_rows = cur.odd_empty;
    end else if (run.ok) begin
      emit = 1'b1;
      res = run.r;
    end
    nxt = st;
  end

endmodule

// File: src/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks for the sprite row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rsd_checker
  import rsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // frame report carries only the repeat flag
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == KIND_FRAME |-> m_tdata[41:0] == 42'd0 && m_tdata[47:43] == 5'd0)
    else $error("frame report with run fields set");

  // a pixel run is never empty or transparent
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == KIND_RUN |->
      m_tdata[25:20] != 6'd0 && m_tdata[41:34] != 8'd0 && !m_tdata[42])
    else $error("empty or transparent run emitted");

  // nothing is shown right after reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rle_sprite_row_decoder rsd_checker u_rsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
